// ----- rtl/m4te_pkg.sv -----
package m4te_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int SumW     = ProdW - FracBits + 2;

  typedef enum logic [2:0] {
    OP_WR_CUR  = 3'd0,
    OP_WR_STG  = 3'd1,
    OP_XFORM   = 3'd2,
    OP_CONCAT  = 3'd3,
    OP_TRANSP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_XFORM,
    ST_CONCAT,
    ST_COPY,
    ST_TRANSP
  } state_t;

  // reset value of element i of the identity matrix
  function automatic logic [DataW-1:0] ident_elem(input logic [3:0] idx);
    logic [DataW-1:0] one;
    one = DataW'(1) << FracBits;
    return (idx[3:2] == idx[1:0]) ? one : '0;
  endfunction

  // saturate a wide signed sum to 32 bits
  function automatic logic [DataW-1:0] sat32(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = -hi - SumW'(1);
    if (s > hi) return {1'b0, {(DataW-1){1'b1}}};
    if (s < lo) return {1'b1, {(DataW-1){1'b0}}};
    return s[DataW-1:0];
  endfunction

endpackage

// ----- rtl/m4te_dot4.sv -----
module m4te_dot4 (
  input  logic                         clk,
  input  logic [m4te_pkg::DataW-1:0]   a0, a1, a2, a3,
  input  logic [m4te_pkg::DataW-1:0]   b0, b1, b2, b3,
  output logic [m4te_pkg::DataW-1:0]   dot_r
);

  logic signed [m4te_pkg::ProdW-1:0] p_r [4];
  logic signed [m4te_pkg::SumW-1:0]  s_nxt;
  logic signed [m4te_pkg::SumW-1:0]  t [4];

  // four multipliers, registered
  always_ff @(posedge clk) begin
    p_r[0] <= signed'(a0) * signed'(b0);
    p_r[1] <= signed'(a1) * signed'(b1);
    p_r[2] <= signed'(a2) * signed'(b2);
    p_r[3] <= signed'(a3) * signed'(b3);
  end

  // floor shift, exact sum, saturate
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = m4te_pkg::SumW'(p_r[i] >>> m4te_pkg::FracBits);
    end
    s_nxt = t[0] + t[1] + t[2] + t[3];
  end

  always_ff @(posedge clk) begin
    dot_r <= m4te_pkg::sat32(s_nxt);
  end

endmodule

// ----- rtl/m4te_mat_ram.sv -----
module m4te_mat_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [1:0]                  wrow,
  input  logic [3:0]                  wmask,
  input  logic [m4te_pkg::DataW-1:0]  wdata [4],
  input  logic [1:0]                  rrow,
  output logic [m4te_pkg::DataW-1:0]  rdata_r [4]
);

  logic [4*m4te_pkg::DataW-1:0] mem [4];

  // row wide memory with per element write enables
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (we && wmask[i]) begin
        mem[wrow][i*m4te_pkg::DataW +: m4te_pkg::DataW] <= wdata[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      rdata_r[i] <= mem[rrow][i*m4te_pkg::DataW +: m4te_pkg::DataW];
    end
  end

endmodule

// ----- rtl/mat4_transform_engine_top.sv -----
// 4x4 fixed point matrix engine, Q16.16 elements, current and staging matrix.
// start/busy command channel: a command transfers on a clock edge with start
// high and busy low. op 0/1 write one element of current/staging, op 2
// transforms (in_x..in_w) by current, op 3 sets current = current*staging,
// op 4 transposes current. Unused ops do nothing.
// Only op 2 gives a result: out_valid pulses one cycle with out_x..out_w; the
// receiver cannot stall, so no result buffering is needed.
// Sequencing: element writes complete while busy stays low. Transform reads one
// matrix row per cycle and feeds the four-multiplier dot unit (multiply, sum
// stages); busy stays high until the last result is collected, and out_valid
// rises as busy falls, when the next command can transfer.
// Concatenate keeps busy high while each of 16 elements reads a row of
// current and a row of the staging transposed copy, and then while the rows
// are copied back.
// Transpose keeps busy high for 4 row reads into a temp buffer,
// then 4 row writes of its columns.
// After rst_n low both matrices are rebuilt to identity by a row by row
// pass; busy stays high meanwhile.
module mat4_transform_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_op,
  input  logic [3:0]                  in_elem_index,
  input  logic signed [31:0]          in_elem_value,
  input  logic signed [31:0]          in_x,
  input  logic signed [31:0]          in_y,
  input  logic signed [31:0]          in_z,
  input  logic signed [31:0]          in_w,
  output logic                        out_valid,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y,
  output logic signed [31:0]          out_z,
  output logic signed [31:0]          out_w
);

  localparam int W = m4te_pkg::DataW;

  m4te_pkg::state_t ph_r, ph_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [W-1:0] vec_r [4];
  logic [W-1:0] acc_r [4];
  logic [W-1:0] tmp_r [16];
  logic        accept;

  // current memory ports
  logic         c_we;
  logic [1:0]   c_wrow, c_rrow;
  logic [3:0]   c_wmask;
  logic [W-1:0] c_wdata [4];
  logic [W-1:0] c_rdata [4];
  // staging memory (stored by column, so a read gives one column)
  logic         s_we;
  logic [1:0]   s_wrow, s_rrow;
  logic [3:0]   s_wmask;
  logic [W-1:0] s_wdata [4];
  logic [W-1:0] s_rdata [4];

  logic [W-1:0] dot;
  logic [W-1:0] b_sel [4];

  m4te_mat_ram u_cur (
    .clk, .we(c_we), .wrow(c_wrow), .wmask(c_wmask), .wdata(c_wdata),
    .rrow(c_rrow), .rdata_r(c_rdata)
  );

  m4te_mat_ram u_stg (
    .clk, .we(s_we), .wrow(s_wrow), .wmask(s_wmask), .wdata(s_wdata),
    .rrow(s_rrow), .rdata_r(s_rdata)
  );

  m4te_dot4 u_dot (
    .clk,
    .a0(c_rdata[0]), .a1(c_rdata[1]), .a2(c_rdata[2]), .a3(c_rdata[3]),
    .b0(b_sel[0]), .b1(b_sel[1]), .b2(b_sel[2]), .b3(b_sel[3]),
    .dot_r(dot)
  );

  assign busy   = (ph_r != m4te_pkg::ST_IDLE);
  assign accept = start && !busy;

  // second operand: input vector for transform, staging column otherwise
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b_sel[i] = (ph_r == m4te_pkg::ST_XFORM) ? vec_r[i] : s_rdata[i];
    end
  end

  // sequencer: cnt bits pick row/column, results land after the memory read, multiply and sum registers
  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r + 6'd1;
    c_we = 1'b0; c_wrow = '0; c_wmask = '0; c_rrow = cnt_r[1:0];
    s_we = 1'b0; s_wrow = '0; s_wmask = '0; s_rrow = cnt_r[1:0];
    for (int i = 0; i < 4; i++) begin
      c_wdata[i] = '0;
      s_wdata[i] = '0;
    end
    unique case (ph_r)
      m4te_pkg::ST_INIT: begin
        c_we = 1'b1; s_we = 1'b1;
        c_wrow = cnt_r[1:0]; s_wrow = cnt_r[1:0];
        c_wmask = '1; s_wmask = '1;
        for (int i = 0; i < 4; i++) begin
          c_wdata[i] = m4te_pkg::ident_elem({cnt_r[1:0], 2'(i)});
          s_wdata[i] = m4te_pkg::ident_elem({cnt_r[1:0], 2'(i)});
        end
        if (cnt_r == 6'd3) ph_nxt = m4te_pkg::ST_IDLE;
      end
      m4te_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          unique case (in_op)
            m4te_pkg::OP_WR_CUR: begin
              c_we = 1'b1; c_wrow = in_elem_index[3:2];
              c_wmask = 4'b0001 << in_elem_index[1:0];
              for (int i = 0; i < 4; i++) c_wdata[i] = in_elem_value;
            end
            m4te_pkg::OP_WR_STG: begin
              // staging stored transposed: row = column index
              s_we = 1'b1; s_wrow = in_elem_index[1:0];
              s_wmask = 4'b0001 << in_elem_index[3:2];
              for (int i = 0; i < 4; i++) s_wdata[i] = in_elem_value;
            end
            m4te_pkg::OP_XFORM:  ph_nxt = m4te_pkg::ST_XFORM;
            m4te_pkg::OP_CONCAT: ph_nxt = m4te_pkg::ST_CONCAT;
            m4te_pkg::OP_TRANSP: ph_nxt = m4te_pkg::ST_TRANSP;
            default: ;
          endcase
        end
      end
      m4te_pkg::ST_XFORM: begin
        if (cnt_r == 6'd6) ph_nxt = m4te_pkg::ST_IDLE;
      end
      m4te_pkg::ST_CONCAT: begin
        // element e = cnt: row cnt[3:2], column cnt[1:0], result after read, multiply and sum registers
        c_rrow = cnt_r[3:2];
        s_rrow = cnt_r[1:0];
        if (cnt_r == 6'd18) begin
          ph_nxt = m4te_pkg::ST_COPY; cnt_nxt = '0;
        end
      end
      m4te_pkg::ST_COPY: begin
        c_we = 1'b1; c_wrow = cnt_r[1:0]; c_wmask = '1;
        for (int i = 0; i < 4; i++) c_wdata[i] = tmp_r[{cnt_r[1:0], 2'(i)}];
        if (cnt_r == 6'd3) ph_nxt = m4te_pkg::ST_IDLE;
      end
      m4te_pkg::ST_TRANSP: begin
        // read rows 0..3, then write columns as rows from tmp
        c_rrow = cnt_r[1:0];
        if (cnt_r >= 6'd5 && cnt_r <= 6'd8) begin
          c_we = 1'b1; c_wrow = 2'(cnt_r - 6'd5); c_wmask = '1;
          for (int i = 0; i < 4; i++) begin
            c_wdata[i] = tmp_r[{2'(i), 2'(cnt_r - 6'd5)}];
          end
        end
        if (cnt_r == 6'd8) ph_nxt = m4te_pkg::ST_IDLE;
      end
      default: ph_nxt = m4te_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= m4te_pkg::ST_INIT;
      cnt_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // vector capture, result collection and temp matrix
  always_ff @(posedge clk) begin
    if (accept) begin
      vec_r[0] <= in_x; vec_r[1] <= in_y; vec_r[2] <= in_z; vec_r[3] <= in_w;
    end
    if (ph_r == m4te_pkg::ST_XFORM && cnt_r >= 6'd3) acc_r[2'(cnt_r - 6'd3)] <= dot;
    if (ph_r == m4te_pkg::ST_CONCAT && cnt_r >= 6'd3) tmp_r[4'(cnt_r - 6'd3)] <= dot;
    if (ph_r == m4te_pkg::ST_TRANSP && cnt_r >= 6'd1 && cnt_r <= 6'd4) begin
      for (int i = 0; i < 4; i++) tmp_r[{2'(cnt_r - 6'd1), 2'(i)}] <= c_rdata[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= (ph_r == m4te_pkg::ST_XFORM && cnt_r == 6'd6);
  end

  assign out_x = acc_r[0];
  assign out_y = acc_r[1];
  assign out_z = acc_r[2];
  assign out_w = acc_r[3];

  // checks
  a_busy_after_xf: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == m4te_pkg::OP_XFORM |=> busy) else $error("no busy");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("valid while busy");
  a_no_valid_init: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == m4te_pkg::ST_INIT |-> !out_valid) else $error("valid in init");

endmodule

// ----- sim/mat4_transform_engine_top_tb.sv -----
`timescale 1ns / 100ps

module mat4_transform_engine_top_tb;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] vx, vy, vz, vw;
  } cmd_t;

  typedef struct {
    logic signed [31:0] x, y, z, w;
  } vec_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_op;
  logic [3:0] in_elem_index;
  logic signed [31:0] in_elem_value, in_x, in_y, in_z, in_w;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;

  cmd_t pending_cmds[$];
  vec_t expected_vecs[$];
  logic signed [31:0] cur_mat[16];
  logic signed [31:0] stg_mat[16];
  int gap_left;
  int no_idle;
  int errors;

  mat4_transform_engine_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_elem_index(in_elem_index), .in_elem_value(in_elem_value),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // fixed point product, floor shift
  function automatic logic signed [63:0] fx_prod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> m4te_pkg::FracBits;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] s);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] row_dot(input int r, input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] c,
                                                 input logic signed [31:0] d);
    logic signed [63:0] s;
    s = fx_prod(cur_mat[4*r], a) + fx_prod(cur_mat[4*r+1], b)
      + fx_prod(cur_mat[4*r+2], c) + fx_prod(cur_mat[4*r+3], d);
    return clamp32(s);
  endfunction

  // update matrix state for an accepted command, queue any expected vector
  task automatic apply_cmd(input cmd_t c);
    logic signed [31:0] prod_mat[16];
    logic signed [31:0] t;
    vec_t v;
    case (c.op)
      m4te_pkg::OP_WR_CUR: cur_mat[c.idx] = c.val;
      m4te_pkg::OP_WR_STG: stg_mat[c.idx] = c.val;
      m4te_pkg::OP_XFORM: begin
        v.x = row_dot(0, c.vx, c.vy, c.vz, c.vw);
        v.y = row_dot(1, c.vx, c.vy, c.vz, c.vw);
        v.z = row_dot(2, c.vx, c.vy, c.vz, c.vw);
        v.w = row_dot(3, c.vx, c.vy, c.vz, c.vw);
        expected_vecs.push_back(v);
      end
      m4te_pkg::OP_CONCAT: begin
        for (int r = 0; r < 4; r++)
          for (int k = 0; k < 4; k++)
            prod_mat[4*r+k] = row_dot(r, stg_mat[k], stg_mat[4+k], stg_mat[8+k], stg_mat[12+k]);
        cur_mat = prod_mat;
      end
      m4te_pkg::OP_TRANSP: begin
        for (int r = 0; r < 4; r++)
          for (int k = r + 1; k < 4; k++) begin
            t = cur_mat[4*r+k];
            cur_mat[4*r+k] = cur_mat[4*k+r];
            cur_mat[4*k+r] = t;
          end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] op);
    cmd_t c;
    c.op = op;
    c.idx = $urandom_range(0, 15);
    c.val = rand_elem();
    c.vx = rand_elem();
    c.vy = rand_elem();
    c.vz = rand_elem();
    c.vw = rand_elem();
    return c;
  endfunction

  // driver: issue commands with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      apply_cmd('{in_op, in_elem_index, in_elem_value, in_x, in_y, in_z, in_w});
      if (pending_cmds.size() > 0 && (pending_cmds.size() <= no_idle || $urandom_range(0, 3) != 0))
        drive_next();
      else begin
        start <= 1'b0;
        gap_left <= $urandom_range(1, 3);
      end
    end else if (!start) begin
      if (gap_left > 0)
        gap_left <= gap_left - 1;
      else if (pending_cmds.size() > 0)
        drive_next();
    end
  end

  task automatic drive_next();
    cmd_t c;
    c = pending_cmds.pop_front();
    start <= 1'b1;
    in_op <= c.op;
    in_elem_index <= c.idx;
    in_elem_value <= c.val;
    in_x <= c.vx;
    in_y <= c.vy;
    in_z <= c.vz;
    in_w <= c.vw;
  endtask

  // monitor: compare every result transfer with the oldest expected vector
  always @(posedge clk) begin
    vec_t e;
    if (rst_n && out_valid) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time, out_x, out_y, out_z,
                 out_w);
        errors++;
      end else begin
        e = expected_vecs.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          errors++;
        end
        if (out_w !== e.w) begin
          $display("%0t: out_w expected %h actual %h", $time, e.w, out_w);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    cmd_t c;
    int n;
    errors = 0;
    no_idle = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = m4te_pkg::OP_WR_CUR;
    in_elem_index = '0;
    in_elem_value = '0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    for (int i = 0; i < 16; i++) begin
      cur_mat[i] = m4te_pkg::ident_elem(4'(i));
      stg_mat[i] = m4te_pkg::ident_elem(4'(i));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity transforms of extremes, saturation, all ops, unused ops
    c = make_cmd(m4te_pkg::OP_XFORM);
    c.vx = 32'sh7fffffff; c.vy = 32'sh80000000; c.vz = 32'sh0; c.vw = -32'sh1;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_WR_CUR); c.idx = 4'd0; c.val = 32'sh7fffffff;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_WR_CUR); c.idx = 4'd1; c.val = 32'sh7fffffff;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_WR_CUR); c.idx = 4'd15; c.val = 32'sh80000000;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_XFORM);
    c.vx = 32'sh7fffffff; c.vy = 32'sh7fffffff; c.vz = 32'sh7fffffff; c.vw = 32'sh7fffffff;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_XFORM);
    c.vx = -32'sh1; c.vy = -32'sh3; c.vz = 32'sh80000000; c.vw = 32'sh80000000;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_WR_STG); c.idx = 4'd3; c.val = 32'sh00028000;
    pending_cmds.push_back(c);
    c = make_cmd(m4te_pkg::OP_WR_STG); c.idx = 4'd12; c.val = 32'shfffe8000;
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(m4te_pkg::OP_CONCAT));
    pending_cmds.push_back(make_cmd(m4te_pkg::OP_XFORM));
    pending_cmds.push_back(make_cmd(m4te_pkg::OP_TRANSP));
    pending_cmds.push_back(make_cmd(m4te_pkg::OP_XFORM));
    pending_cmds.push_back(make_cmd(3'd5));
    pending_cmds.push_back(make_cmd(3'd6));
    pending_cmds.push_back(make_cmd(3'd7));
    pending_cmds.push_back(make_cmd(m4te_pkg::OP_XFORM));

    // random: weighted toward writes and transforms
    for (int i = 0; i < 400; i++) begin
      n = $urandom_range(0, 99);
      if (n < 30) c = make_cmd(m4te_pkg::OP_WR_CUR);
      else if (n < 50) c = make_cmd(m4te_pkg::OP_WR_STG);
      else if (n < 85) c = make_cmd(m4te_pkg::OP_XFORM);
      else if (n < 91) c = make_cmd(m4te_pkg::OP_CONCAT);
      else if (n < 96) c = make_cmd(m4te_pkg::OP_TRANSP);
      else c = make_cmd(3'($urandom_range(5, 7)));
      pending_cmds.push_back(c);
    end
    no_idle = 60;

    // drain
    wait (pending_cmds.size() == 0 && start == 1'b0);
    wait (expected_vecs.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
